// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ----- hdl/kpdr_pkg.sv -----
package kpdr_pkg;

   localparam int unsigned VALUE_W    = 14;
   localparam int unsigned PERIOD_W   = 8;
   localparam int unsigned KEY_W      = 4;
   localparam int unsigned PCT_W      = 7;
   localparam int unsigned CHAR_W     = 7;
   localparam int unsigned PROD_W     = 21;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 14;
   localparam int unsigned DIG_IDX_W  = 3;

   typedef logic [VALUE_W-1:0]    value_type;
   typedef logic [PERIOD_W-1:0]   period_type;
   typedef logic [KEY_W-1:0]      key_type;
   typedef logic [PCT_W-1:0]      pct_type;
   typedef logic [CHAR_W-1:0]     char_type;
   typedef logic [PROD_W-1:0]     prod_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [DIG_IDX_W-1:0]  dig_idx_type;

   // register indexes
   localparam csr_idx_type CSR_FULL_SCALE    = 2'd0;
   localparam csr_idx_type CSR_PRESET_VALUE  = 2'd1;
   localparam csr_idx_type CSR_REPORT_PERIOD = 2'd2;

   localparam value_type  FULL_SCALE_RST    = 14'd16000;
   localparam value_type  PRESET_VALUE_RST  = 14'd100;
   localparam period_type REPORT_PERIOD_RST = 8'd200;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_KEY  = 1'b1;

   localparam key_type KEY_FIRST_DIGIT  = 4'd0;
   localparam key_type KEY_LAST_DIGIT   = 4'd9;
   localparam key_type KEY_FIRST_LETTER = 4'd10;
   localparam key_type KEY_LAST_LETTER  = 4'd13;
   localparam key_type KEY_HASH         = 4'd15;

   localparam char_type ASCII_ZERO = 7'd48;

   // x / 100 == (x * RECIP_100) >> DIV_SHIFT, exact for x up to 16383 * 99
   localparam prod_type    RECIP_100      = 21'd1342178;
   localparam int unsigned DIV_SHIFT      = 27;
   localparam dig_idx_type LAST_DIGIT_IDX = 3'd4;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_PRESET,
      OP_HASH,
      OP_REPORT
   } op_type;

   typedef struct packed {
      op_type  op;
      pct_type pct;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH_DIV,
      ST_HASH_EMIT,
      ST_DIGIT
   } back_state_type;

   function automatic value_type pow10(input dig_idx_type idx);
      value_type p;
      case (idx)
         3'd0:    p = 14'd10000;
         3'd1:    p = 14'd1000;
         3'd2:    p = 14'd100;
         3'd3:    p = 14'd10;
         default: p = 14'd1;
      endcase
      return p;
   endfunction

endpackage

// ----- hdl/kpdr_if.sv -----
interface kpdr_req_if;
   import kpdr_pkg::*;
   logic    valid;
   logic    ready;
   logic    command;
   key_type key_code;

   modport source (output valid, output command, output key_code, input ready);
   modport sink   (input valid, input command, input key_code, output ready);
endinterface

interface kpdr_rsp_if;
   import kpdr_pkg::*;
   logic      valid;
   logic      ready;
   value_type compare_out;
   logic      char_valid;
   char_type  ascii_char;
   logic      last;

   modport source (output valid, output compare_out, output char_valid,
                   output ascii_char, output last, input ready);
   modport sink   (input valid, input compare_out, input char_valid,
                   input ascii_char, input last, output ready);
endinterface

// ----- hdl/kpdr_front.sv -----
module kpdr_front (
   input  logic                 clock,
   input  logic                 reset,
   kpdr_req_if.sink             req,
   input  kpdr_pkg::period_type report_period,
   output logic                 push_valid,
   input  logic                 push_ready,
   output kpdr_pkg::cmd_type    push_cmd
);
   import kpdr_pkg::*;

   logic       phase_ff, phase_in;
   key_type    tens_ff, tens_in;
   key_type    ones_ff, ones_in;
   period_type tick_ff, tick_in;
   logic       accept;
   logic [PERIOD_W:0] tick_next;
   logic       report;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;

   // 9-bit compare also covers the counter wrapping past 255
   assign tick_next = {1'b0, tick_ff} + (PERIOD_W+1)'(1);
   assign report    = tick_next >= {1'b0, report_period};

   always_comb begin
      phase_in     = phase_ff;
      tens_in      = tens_ff;
      ones_in      = ones_ff;
      tick_in      = tick_ff;
      push_cmd.op  = OP_HOLD;
      push_cmd.pct = ({3'b0, tens_ff} << 3) + ({3'b0, tens_ff} << 1) + {3'b0, ones_ff};
      if (req.command == CMD_KEY) begin
         case (req.key_code) inside
            [KEY_FIRST_DIGIT:KEY_LAST_DIGIT]: begin
               if (phase_ff) begin
                  tens_in = req.key_code;
               end else begin
                  ones_in = req.key_code;
               end
               phase_in = !phase_ff;
            end
            [KEY_FIRST_LETTER:KEY_LAST_LETTER]: push_cmd.op = OP_PRESET;
            KEY_HASH: push_cmd.op = OP_HASH;
            default: push_cmd.op = OP_HOLD;
         endcase
      end else begin
         if (report) begin
            push_cmd.op = OP_REPORT;
            tick_in     = '0;
         end else begin
            tick_in = tick_next[PERIOD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b1;
         tens_ff  <= '0;
         ones_ff  <= '0;
         tick_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         tens_ff  <= tens_in;
         ones_ff  <= ones_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

// ----- hdl/kpdr_queue.sv -----
`include "assert_macros.svh"

module kpdr_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  kpdr_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output kpdr_pkg::cmd_type pop_cmd
);
   import kpdr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `ASSERT_NEXT(a_push_only_grows, clock, reset, push && !pop, count_ff != '0)

endmodule

// ----- hdl/kpdr_back.sv -----
`include "assert_macros.svh"

module kpdr_back (
   input  logic                clock,
   input  logic                reset,
   input  kpdr_pkg::value_type full_scale,
   input  kpdr_pkg::value_type preset_value,
   input  logic                q_valid,
   output logic                q_pop,
   input  kpdr_pkg::cmd_type   q_cmd,
   kpdr_rsp_if.source          rsp
);
   import kpdr_pkg::*;

   back_state_type state_ff, state_in;
   value_type      cmp_ff, cmp_in;
   prod_type       prod_ff, prod_in;
   value_type      rem_ff, rem_in;
   dig_idx_type    digit_idx_ff, digit_idx_in;

   logic           out_valid_ff;
   value_type      out_cmp_ff;
   logic           out_cv_ff;
   char_type       out_char_ff;
   logic           out_last_ff;

   logic           out_free;
   logic           emit;
   value_type      emit_cmp;
   logic           emit_cv;
   char_type       emit_char;
   logic           emit_last;

   logic [2*PROD_W-1:0] recip_prod;
   value_type           pow;
   key_type             digit;
   logic [VALUE_W+2:0]  rem_diff;

   assign out_free   = !out_valid_ff || rsp.ready;
   assign recip_prod = {{PROD_W{1'b0}}, prod_ff} * {{PROD_W{1'b0}}, RECIP_100};
   assign pow        = pow10(digit_idx_ff);

   // digit = how many multiples of the current power fit in the remainder
   always_comb begin
      digit = '0;
      for (int k = 1; k <= 9; k++) begin
         if ({3'b0, rem_ff} >= (VALUE_W+3)'(k) * {3'b0, pow}) begin
            digit = KEY_W'(k);
         end
      end
   end

   assign rem_diff = {3'b0, rem_ff} - (VALUE_W+3)'(digit) * {3'b0, pow};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_cmd.op == OP_HASH) begin
               state_in = ST_HASH_DIV;
            end else if (q_valid && q_cmd.op == OP_REPORT) begin
               state_in = ST_DIGIT;
            end
         end
         ST_HASH_DIV: state_in = ST_HASH_EMIT;
         ST_HASH_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIGIT: begin
            if (out_free && digit_idx_ff == LAST_DIGIT_IDX) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop        = 1'b0;
      emit         = 1'b0;
      emit_cmp     = cmp_ff;
      emit_cv      = 1'b0;
      emit_char    = '0;
      emit_last    = 1'b1;
      cmp_in       = cmp_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      digit_idx_in = digit_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.op)
                  OP_HOLD: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        emit  = 1'b1;
                     end
                  end
                  OP_PRESET: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        emit     = 1'b1;
                        cmp_in   = preset_value;
                        emit_cmp = preset_value;
                     end
                  end
                  OP_HASH: begin
                     q_pop   = 1'b1;
                     prod_in = {{(PROD_W-VALUE_W){1'b0}}, full_scale}
                               * {{(PROD_W-PCT_W){1'b0}}, q_cmd.pct};
                  end
                  OP_REPORT: begin
                     q_pop        = 1'b1;
                     rem_in       = cmp_ff;
                     digit_idx_in = '0;
                  end
                  default: q_pop = 1'b0;
               endcase
            end
         end
         ST_HASH_DIV: begin
            cmp_in = recip_prod[DIV_SHIFT +: VALUE_W];
         end
         ST_HASH_EMIT: begin
            emit = out_free;
         end
         ST_DIGIT: begin
            if (out_free) begin
               emit         = 1'b1;
               emit_cv      = 1'b1;
               emit_char    = ASCII_ZERO + {3'b0, digit};
               emit_last    = digit_idx_ff == LAST_DIGIT_IDX;
               rem_in       = rem_diff[VALUE_W-1:0];
               digit_idx_in = digit_idx_ff + DIG_IDX_W'(1);
            end
         end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmp_ff   <= cmp_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      digit_idx_ff <= digit_idx_in;
      if (emit) begin
         out_cmp_ff  <= emit_cmp;
         out_cv_ff   <= emit_cv;
         out_char_ff <= emit_char;
         out_last_ff <= emit_last;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.compare_out = out_cmp_ff;
   assign rsp.char_valid  = out_cv_ff;
   assign rsp.ascii_char  = out_char_ff;
   assign rsp.last        = out_last_ff;

   `ASSERT_IMPL(a_digit_idx_range, clock, reset, state_ff == ST_DIGIT, digit_idx_ff <= LAST_DIGIT_IDX)
   `ASSERT_NEXT(a_hash_to_div, clock, reset, q_pop && q_cmd.op == OP_HASH, state_ff == ST_HASH_DIV)
   `ASSERT_IMPL(a_emit_has_room, clock, reset, emit, out_free)

endmodule

// ----- hdl/keypad_pwm_duty_entry_reporter.sv -----
// Keypad PWM duty entry and decimal reporter.
// req_ch carries one beat per keypad key (command 1, key_code) or timer tick
// (command 0). Digits fill tens then ones; '#' loads full_scale * pct / 100,
// A to D load preset_value, '*' is ignored. Every report_period ticks the
// compare value goes out as five ASCII digit beats, most significant first.
// rsp_ch carries one beat per key or plain tick and five per report tick;
// last marks the final beat of each input beat.
// The front stage keeps the digit and tick state and accepts one beat per
// cycle, while the queue has room, into a QUEUE_DEPTH entry queue. The back
// stage owns the compare value and a registered output slot. A plain beat
// reaches rsp_ch through the queue and the output slot; the back stage
// retires one per cycle while rsp_ch takes them. '#' runs through multiply,
// reciprocal multiply and emit; a report loads the value, then emits digits.
// req_ch.ready drops only when the queue is full.
// A stalled rsp_ch holds its beat; the back stage then waits, the queue fills
// and the front stalls. Reset (synchronous) empties the queue, drops
// rsp_ch.valid and loads the register reset values.
// csr_we writes csr_wdata to register csr_index (0 full_scale, 1
// preset_value, 2 report_period); other indexes are dropped.
module keypad_pwm_duty_entry_reporter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   kpdr_req_if.sink               req_ch,
   kpdr_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  kpdr_pkg::csr_idx_type  csr_index,
   input  kpdr_pkg::csr_data_type csr_wdata
);
   import kpdr_pkg::*;

   value_type  full_scale_ff;
   value_type  preset_value_ff;
   period_type report_period_ff;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    q_valid, q_pop;
   cmd_type q_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff    <= FULL_SCALE_RST;
         preset_value_ff  <= PRESET_VALUE_RST;
         report_period_ff <= REPORT_PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FULL_SCALE:    full_scale_ff    <= csr_wdata;
            CSR_PRESET_VALUE:  preset_value_ff  <= csr_wdata;
            CSR_REPORT_PERIOD: report_period_ff <= csr_wdata[PERIOD_W-1:0];
            default:           full_scale_ff    <= full_scale_ff;
         endcase
      end
   end

   kpdr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .report_period (report_period_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_cmd      (push_cmd)
   );

   kpdr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (q_valid),
      .pop_ready  (q_pop),
      .pop_cmd    (q_cmd)
   );

   kpdr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .full_scale   (full_scale_ff),
      .preset_value (preset_value_ff),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_cmd        (q_cmd),
      .rsp          (rsp_ch)
   );

endmodule
